// ----- src/clock_trim_pid_regulator_top_assert.svh -----
// Assertion macros for the clock trim PID regulator.
`ifndef CLOCK_TRIM_PID_REGULATOR_TOP_ASSERT_SVH
`define CLOCK_TRIM_PID_REGULATOR_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS

// cons must hold in the same cycle as ante
`define CTPR_ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("clock trim regulator: assertion failed");

// cons must hold in the cycle after ante
`define CTPR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("clock trim regulator: assertion failed");

`else

`define CTPR_ASSERT_IMPLIES(lbl, clk, rst, ante, cons)

`define CTPR_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ----- src/ctpr_pkg.sv -----
// Shared types and constants for the clock trim PID regulator.
`timescale 1ns / 1ps

package ctpr_pkg;

   localparam int TGT_W      = 10;
   localparam int WIN_W      = 10;
   localparam int NOM_W      = 16;
   localparam int GAIN_W     = 16;
   localparam int STAMP_IN_W = 32;
   localparam int PERIOD_W   = 11;
   localparam int ERR_W      = 12;
   localparam int PS_W       = 16;
   localparam int CNT_W      = $clog2(PS_W);
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_TARGET  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NOMINAL = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_P_GAIN  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_I_GAIN  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_D_GAIN  = 3'd5;

   localparam logic REQ_START = 1'b0;
   localparam logic REQ_TICK  = 1'b1;

   typedef struct packed {
      logic [TGT_W-1:0]  target_period_ms;
      logic [WIN_W-1:0]  window_ms;
      logic [NOM_W-1:0]  nominal_ticks;
      logic [GAIN_W-1:0] p_gain;
      logic [GAIN_W-1:0] i_gain;
      logic [GAIN_W-1:0] d_gain;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      target_period_ms: 10'd250,
      window_ms:        10'd50,
      nominal_ticks:    16'd8192,
      p_gain:           16'd32768,
      i_gain:           16'd6554,
      d_gain:           16'd655
   };

   localparam logic [PERIOD_W-1:0] LAST_PERIOD_RESET = 11'd250;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_WIN,
      ST_SUM,
      ST_MUL_P,
      ST_MUL_I,
      ST_MUL_D,
      ST_ACC_D,
      ST_CHECK,
      ST_DIV1,
      ST_MUL_A,
      ST_MUL_B,
      ST_DIV2_LD,
      ST_DIV2,
      ST_FINAL,
      ST_EMIT
   } state_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_START,
      OP_TICK,
      OP_WIN,
      OP_SUM,
      OP_MUL_P,
      OP_MUL_I,
      OP_MUL_D,
      OP_ACC_D,
      OP_CHECK,
      OP_DIV,
      OP_MUL_A,
      OP_MUL_B,
      OP_DIV_LD,
      OP_FINAL,
      OP_EMIT
   } op_type;

   typedef struct packed {
      op_type op;
   } seq_ctl_type;

   typedef struct packed {
      logic c_in_range;
      logic rsp_full;
   } dp_stat_type;

endpackage

// ----- src/ctpr_req_if.sv -----
// Request channel: start or tick word with its millisecond stamp.
`timescale 1ns / 1ps

interface ctpr_req_if
   import ctpr_pkg::*;
();
   logic                  valid;
   logic                  ready;
   logic                  req_type;
   logic [STAMP_IN_W-1:0] time_ms;

   modport source (output valid, output req_type, output time_ms, input ready);
   modport sink   (input valid, input req_type, input time_ms, output ready);
endinterface

// ----- src/ctpr_rsp_if.sv -----
// Response channel: new prescaler word with status flags.
`timescale 1ns / 1ps

interface ctpr_rsp_if
   import ctpr_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [PS_W-1:0]     prescaler;
   logic [PERIOD_W-1:0] period_used;
   logic                out_of_window;
   logic                clamped;

   modport source (output valid, output prescaler, output period_used,
                   output out_of_window, output clamped, input ready);
   modport sink   (input valid, input prescaler, input period_used,
                   input out_of_window, input clamped, output ready);
endinterface

// ----- src/ctpr_seq.sv -----
// Sequencer stepping the shared datapath through one request.
`timescale 1ns / 1ps

module ctpr_seq
   import ctpr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_type,
   output logic        req_ready,
   input  logic        rsp_ready,
   input  dp_stat_type stat,
   output seq_ctl_type ctl
);

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      ctl.op    = OP_NONE;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_type == REQ_START) begin
                  ctl.op   = OP_START;
                  state_in = ST_EMIT;
               end else begin
                  ctl.op   = OP_TICK;
                  state_in = ST_WIN;
               end
            end
         end
         ST_WIN: begin
            ctl.op   = OP_WIN;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            ctl.op   = OP_SUM;
            state_in = ST_MUL_P;
         end
         ST_MUL_P: begin
            ctl.op   = OP_MUL_P;
            state_in = ST_MUL_I;
         end
         ST_MUL_I: begin
            ctl.op   = OP_MUL_I;
            state_in = ST_MUL_D;
         end
         ST_MUL_D: begin
            ctl.op   = OP_MUL_D;
            state_in = ST_ACC_D;
         end
         ST_ACC_D: begin
            ctl.op   = OP_ACC_D;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            ctl.op   = OP_CHECK;
            cnt_in   = CNT_W'(PS_W - 1);
            state_in = stat.c_in_range ? ST_DIV1 : ST_FINAL;
         end
         ST_DIV1: begin
            ctl.op = OP_DIV;
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               state_in = ST_MUL_A;
            end
         end
         ST_MUL_A: begin
            ctl.op   = OP_MUL_A;
            state_in = ST_MUL_B;
         end
         ST_MUL_B: begin
            ctl.op   = OP_MUL_B;
            state_in = ST_DIV2_LD;
         end
         ST_DIV2_LD: begin
            ctl.op   = OP_DIV_LD;
            cnt_in   = CNT_W'(PS_W - 1);
            state_in = ST_DIV2;
         end
         ST_DIV2: begin
            ctl.op = OP_DIV;
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               state_in = ST_FINAL;
            end
         end
         ST_FINAL: begin
            ctl.op   = OP_FINAL;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            // wait for the output register to drain
            if (!stat.rsp_full || rsp_ready) begin
               ctl.op   = OP_EMIT;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ----- src/ctpr_dp.sv -----
// Loop state, shared multiplier/accumulator, divide step and output register.
`timescale 1ns / 1ps

module ctpr_dp
   import ctpr_pkg::*;
#(
   parameter int SUM_WIDTH      = 24,
   parameter int GAIN_FRAC_BITS = 16,
   parameter int STAMP_WIDTH    = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cfg_type               cfg,
   input  seq_ctl_type           ctl,
   input  logic [STAMP_IN_W-1:0] time_ms,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output logic [PS_W-1:0]       prescaler,
   output logic [PERIOD_W-1:0]   period_used,
   output logic                  out_of_window,
   output logic                  clamped,
   output dp_stat_type           stat
);

   localparam int DEN_W = TGT_W + GAIN_FRAC_BITS;
   localparam int MB_A  = (SUM_WIDTH > DEN_W) ? SUM_WIDTH : DEN_W;
   localparam int MB_W  = ((MB_A > PS_W) ? MB_A : PS_W) + 1;
   localparam int PW    = MB_W + GAIN_W + 1;
   localparam int ACC_W = PW + 2;

   // loop state
   logic [STAMP_WIDTH-1:0]     last_stamp_ff, last_stamp_in;
   logic [PERIOD_W-1:0]        last_period_ff, last_period_in;
   logic [SUM_WIDTH-1:0]       error_sum_ff, error_sum_in;
   // working registers
   logic [STAMP_WIDTH-1:0]     diff_ff, diff_in;
   logic [ERR_W-1:0]           err_ff, err_in;
   logic [ERR_W-1:0]           dlt_ff, dlt_in;
   logic [PW-1:0]              prod_ff, prod_in;
   logic [ACC_W-1:0]           acc_ff, acc_in;
   logic [DEN_W-1:0]           rem_ff, rem_in;
   logic [PS_W-1:0]            nb_ff, nb_in;
   logic [PS_W-1:0]            q_ff, q_in;
   logic [PS_W-1:0]            res_ps_ff, res_ps_in;
   logic [PERIOD_W-1:0]        res_period_ff, res_period_in;
   logic                       res_oow_ff, res_oow_in;
   logic                       res_clamp_ff, res_clamp_in;
   // output register
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [PS_W-1:0]            rsp_ps_ff, rsp_ps_in;
   logic [PERIOD_W-1:0]        rsp_period_ff, rsp_period_in;
   logic                       rsp_oow_ff, rsp_oow_in;
   logic                       rsp_clamp_ff, rsp_clamp_in;

   logic [TGT_W-1:0]           tgt;
   logic [DEN_W-1:0]           den;
   logic [STAMP_WIDTH-1:0]     now;
   logic [PERIOD_W-1:0]        win_hi;
   logic [TGT_W-1:0]           win_lo;
   logic                       oow;
   logic [PERIOD_W-1:0]        period_w;
   logic signed [ERR_W-1:0]    err_w;
   logic signed [ERR_W-1:0]    dlt_w;
   logic [SUM_WIDTH:0]         sum_wide;
   logic                       sum_ovf;
   logic [SUM_WIDTH-1:0]       sum_sat;
   logic [GAIN_W-1:0]          mul_a;
   logic signed [MB_W-1:0]     mul_b;
   logic signed [PW-1:0]       prod_w;
   logic [ACC_W-1:0]           prod_ext;
   logic [ACC_W-1:0]           den_ext;
   logic [ACC_W-1:0]           den_top;
   logic                       c_pos;
   logic                       c_big;
   logic [DEN_W:0]             rem_sh;
   logic                       q_bit;
   logic [DEN_W:0]             rem_nx;
   logic [ACC_W-1:0]           total;
   logic                       ps_low;
   logic                       ps_high;

   // a zero target behaves as one
   assign tgt = (cfg.target_period_ms == '0) ? TGT_W'(1) : cfg.target_period_ms;
   assign den = {tgt, {GAIN_FRAC_BITS{1'b0}}};
   assign now = STAMP_WIDTH'(time_ms);

   // window test
   assign win_hi   = {1'b0, tgt} + {1'b0, cfg.window_ms};
   assign win_lo   = tgt - cfg.window_ms;
   assign oow      = (diff_ff > STAMP_WIDTH'(win_hi)) ||
                     ((tgt > cfg.window_ms) && (diff_ff < STAMP_WIDTH'(win_lo)));
   assign period_w = oow ? {1'b0, tgt} : diff_ff[PERIOD_W-1:0];

   // error, derivative delta and saturating integral
   assign err_w    = $signed({2'b00, tgt}) - $signed({1'b0, res_period_ff});
   assign dlt_w    = $signed({1'b0, res_period_ff}) - $signed({1'b0, last_period_ff});
   assign sum_wide = {error_sum_ff[SUM_WIDTH-1], error_sum_ff} +
                     {{(SUM_WIDTH+1-ERR_W){err_w[ERR_W-1]}}, err_w};
   assign sum_ovf  = sum_wide[SUM_WIDTH] != sum_wide[SUM_WIDTH-1];
   assign sum_sat  = !sum_ovf ? sum_wide[SUM_WIDTH-1:0] :
                     sum_wide[SUM_WIDTH] ? {1'b1, {(SUM_WIDTH-1){1'b0}}} :
                                           {1'b0, {(SUM_WIDTH-1){1'b1}}};

   // shared multiplier operands
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (ctl.op)
         OP_MUL_P: begin
            mul_a = cfg.p_gain;
            mul_b = {{(MB_W-ERR_W){err_ff[ERR_W-1]}}, err_ff};
         end
         OP_MUL_I: begin
            mul_a = cfg.i_gain;
            mul_b = {{(MB_W-SUM_WIDTH){error_sum_ff[SUM_WIDTH-1]}}, error_sum_ff};
         end
         OP_MUL_D: begin
            mul_a = cfg.d_gain;
            mul_b = {{(MB_W-ERR_W){dlt_ff[ERR_W-1]}}, dlt_ff};
         end
         OP_MUL_A: begin
            mul_a = cfg.nominal_ticks;
            mul_b = {{(MB_W-PS_W){1'b0}}, q_ff};
         end
         OP_MUL_B: begin
            mul_a = cfg.nominal_ticks;
            mul_b = {{(MB_W-DEN_W){1'b0}}, rem_ff};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_w   = $signed({1'b0, mul_a}) * mul_b;
   assign prod_ext = {{(ACC_W-PW){prod_ff[PW-1]}}, prod_ff};
   assign den_ext  = {{(ACC_W-DEN_W){1'b0}}, den};
   assign den_top  = {{(ACC_W-DEN_W-PS_W){1'b0}}, den, {PS_W{1'b0}}};

   // range of the control sum c
   assign c_pos = !acc_ff[ACC_W-1] && (acc_ff != '0);
   assign c_big = acc_ff >= den_top;

   // restoring divide step, one quotient bit
   assign rem_sh = {rem_ff, nb_ff[PS_W-1]};
   assign q_bit  = rem_sh >= {1'b0, den};
   assign rem_nx = q_bit ? (rem_sh - {1'b0, den}) : rem_sh;

   // nominal*a + floor(nominal*b/den), then clamp
   assign total   = acc_ff + {{(ACC_W-PS_W){1'b0}}, q_ff};
   assign ps_low  = total == '0;
   assign ps_high = |total[ACC_W-1:PS_W];

   always_comb begin
      last_stamp_in  = last_stamp_ff;
      last_period_in = last_period_ff;
      error_sum_in   = error_sum_ff;
      diff_in        = diff_ff;
      err_in         = err_ff;
      dlt_in         = dlt_ff;
      prod_in        = prod_ff;
      acc_in         = acc_ff;
      rem_in         = rem_ff;
      nb_in          = nb_ff;
      q_in           = q_ff;
      res_ps_in      = res_ps_ff;
      res_period_in  = res_period_ff;
      res_oow_in     = res_oow_ff;
      res_clamp_in   = res_clamp_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_ps_in      = rsp_ps_ff;
      rsp_period_in  = rsp_period_ff;
      rsp_oow_in     = rsp_oow_ff;
      rsp_clamp_in   = rsp_clamp_ff;
      case (ctl.op)
         OP_START: begin
            last_stamp_in  = now;
            last_period_in = {1'b0, tgt};
            error_sum_in   = '0;
            res_period_in  = {1'b0, tgt};
            res_oow_in     = 1'b0;
            res_clamp_in   = cfg.nominal_ticks == '0;
            res_ps_in      = (cfg.nominal_ticks == '0) ? PS_W'(1) : cfg.nominal_ticks;
         end
         OP_TICK: begin
            diff_in       = now - last_stamp_ff;
            last_stamp_in = now;
         end
         OP_WIN: begin
            res_period_in = period_w;
            res_oow_in    = oow;
         end
         OP_SUM: begin
            err_in         = err_w;
            dlt_in         = dlt_w;
            error_sum_in   = sum_sat;
            res_clamp_in   = sum_ovf;
            last_period_in = res_period_ff;
         end
         OP_MUL_P: begin
            prod_in = prod_w;
            acc_in  = den_ext;
         end
         OP_MUL_I: begin
            prod_in = prod_w;
            acc_in  = acc_ff + prod_ext;
         end
         OP_MUL_D: begin
            prod_in = prod_w;
            acc_in  = acc_ff + prod_ext;
         end
         OP_ACC_D: begin
            acc_in = acc_ff - prod_ext;
         end
         OP_CHECK: begin
            if (!c_pos) begin
               acc_in = '0;
               q_in   = '0;
            end else if (c_big) begin
               acc_in = {{(ACC_W-PS_W-1){1'b0}}, 1'b1, {PS_W{1'b0}}};
               q_in   = '0;
            end else begin
               rem_in = acc_ff[PS_W +: DEN_W];
               nb_in  = acc_ff[PS_W-1:0];
            end
         end
         OP_DIV: begin
            rem_in = rem_nx[DEN_W-1:0];
            q_in   = {q_ff[PS_W-2:0], q_bit};
            nb_in  = {nb_ff[PS_W-2:0], 1'b0};
         end
         OP_MUL_A: begin
            prod_in = prod_w;
         end
         OP_MUL_B: begin
            prod_in = prod_w;
            acc_in  = prod_ext;
         end
         OP_DIV_LD: begin
            rem_in = prod_ff[PS_W +: DEN_W];
            nb_in  = prod_ff[PS_W-1:0];
         end
         OP_FINAL: begin
            res_ps_in    = ps_low ? PS_W'(1) : ps_high ? {PS_W{1'b1}} : total[PS_W-1:0];
            res_clamp_in = res_clamp_ff || ps_low || ps_high;
         end
         OP_EMIT: begin
            rsp_valid_in  = 1'b1;
            rsp_ps_in     = res_ps_ff;
            rsp_period_in = res_period_ff;
            rsp_oow_in    = res_oow_ff;
            rsp_clamp_in  = res_clamp_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_stamp_ff  <= '0;
         last_period_ff <= LAST_PERIOD_RESET;
         error_sum_ff   <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         last_stamp_ff  <= last_stamp_in;
         last_period_ff <= last_period_in;
         error_sum_ff   <= error_sum_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      diff_ff       <= diff_in;
      err_ff        <= err_in;
      dlt_ff        <= dlt_in;
      prod_ff       <= prod_in;
      acc_ff        <= acc_in;
      rem_ff        <= rem_in;
      nb_ff         <= nb_in;
      q_ff          <= q_in;
      res_ps_ff     <= res_ps_in;
      res_period_ff <= res_period_in;
      res_oow_ff    <= res_oow_in;
      res_clamp_ff  <= res_clamp_in;
      rsp_ps_ff     <= rsp_ps_in;
      rsp_period_ff <= rsp_period_in;
      rsp_oow_ff    <= rsp_oow_in;
      rsp_clamp_ff  <= rsp_clamp_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign prescaler       = rsp_ps_ff;
   assign period_used     = rsp_period_ff;
   assign out_of_window   = rsp_oow_ff;
   assign clamped         = rsp_clamp_ff;
   assign stat.c_in_range = c_pos && !c_big;
   assign stat.rsp_full   = rsp_valid_ff;

endmodule

// ----- src/clock_trim_pid_regulator_top.sv -----
// Top level of the clock trim PID regulator.
//
//   channel   dir  handshake            word
//   req_chan  in   valid/ready          req_type, time_ms
//   rsp_chan  out  valid/ready          prescaler, period_used, out_of_window, clamped
//   csr_*     in   csr_wr_en, no ready  csr_index, csr_wdata
//
// A start word goes from accept straight to the result load. A tick runs the window
// test, sum, multiplies and range check, then two 16-step restoring divisions on the
// shared subtractor, one quotient bit per cycle, skipped for c out of divisible range.
// req_chan.ready is high only while idle; the result sits in an output register,
// so a new word is taken while rsp_chan stalls, and only the next result load waits.
// Reset is synchronous; there is no clearing pass.
`timescale 1ns / 1ps
`include "clock_trim_pid_regulator_top_assert.svh"

module clock_trim_pid_regulator_top
   import ctpr_pkg::*;
#(
   parameter int SUM_WIDTH      = 24,
   parameter int GAIN_FRAC_BITS = 16,
   parameter int STAMP_WIDTH    = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   ctpr_req_if.sink              req_chan,
   ctpr_rsp_if.source            rsp_chan,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type     cfg_ff, cfg_in;
   seq_ctl_type ctl;
   dp_stat_type stat;
   logic        req_ready;

   // configuration registers; indexes past the list are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_TARGET:  cfg_in.target_period_ms = csr_wdata[TGT_W-1:0];
            CSR_WINDOW:  cfg_in.window_ms        = csr_wdata[WIN_W-1:0];
            CSR_NOMINAL: cfg_in.nominal_ticks    = csr_wdata[NOM_W-1:0];
            CSR_P_GAIN:  cfg_in.p_gain           = csr_wdata[GAIN_W-1:0];
            CSR_I_GAIN:  cfg_in.i_gain           = csr_wdata[GAIN_W-1:0];
            CSR_D_GAIN:  cfg_in.d_gain           = csr_wdata[GAIN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // sequencer: owns the request handshake and the step order
   ctpr_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_type  (req_chan.req_type),
      .req_ready (req_ready),
      .rsp_ready (rsp_chan.ready),
      .stat      (stat),
      .ctl       (ctl)
   );

   assign req_chan.ready = req_ready;

   // datapath: loop state, shared multiplier, divide step, output register
   ctpr_dp #(
      .SUM_WIDTH      (SUM_WIDTH),
      .GAIN_FRAC_BITS (GAIN_FRAC_BITS),
      .STAMP_WIDTH    (STAMP_WIDTH)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .ctl           (ctl),
      .time_ms       (req_chan.time_ms),
      .rsp_ready     (rsp_chan.ready),
      .rsp_valid     (rsp_chan.valid),
      .prescaler     (rsp_chan.prescaler),
      .period_used   (rsp_chan.period_used),
      .out_of_window (rsp_chan.out_of_window),
      .clamped       (rsp_chan.clamped),
      .stat          (stat)
   );

   // prescaler is always clamped to at least one
   `CTPR_ASSERT_IMPLIES(a_ps_nonzero, clock, reset, rsp_chan.valid, rsp_chan.prescaler != '0)
   // one word at a time: busy right after an accept
   `CTPR_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_chan.valid && req_chan.ready, !req_chan.ready)
   // a fresh result only comes out of a busy cycle
   `CTPR_ASSERT_IMPLIES(a_rsp_from_work, clock, reset, $rose(rsp_chan.valid), $past(!req_chan.ready))

endmodule

// ----- test/clock_trim_pid_regulator_top_tb.sv -----
// Self-checking bench for the clock trim PID regulator: queued event words against a trim predictor.
`timescale 1ns / 1ps

module clock_trim_pid_regulator_top_tb;
   import ctpr_pkg::*;

   localparam int     CLOCK_PERIOD = 10;
   localparam int     SUM_BITS     = 24;
   localparam int     FRAC_BITS    = 16;
   localparam int     STAMP_BITS   = 32;
   localparam longint SUM_MAX      = (64'sd1 <<< (SUM_BITS - 1)) - 1;
   localparam longint SUM_MIN      = -SUM_MAX - 1;
   localparam longint PS_MAX       = 65535;
   localparam int     LONG_HOLD    = 400;
   localparam int     TAIL_CYCLES  = 60;
   localparam int     SAT_TICKS    = 60;     // same-sign error train, integral keeps growing
   localparam int     RUN_WORDS    = 140;
   localparam int     RUN_COUNT    = 8;
   localparam longint unsigned CYCLE_LIMIT = 2_000_000;

   typedef struct packed {
      logic                  kind;
      logic [STAMP_IN_W-1:0] stamp;
   } event_word_type;

   typedef struct packed {
      logic [PS_W-1:0]     prescaler;
      logic [PERIOD_W-1:0] period_used;
      logic                out_of_window;
      logic                clamped;
   } trim_word_type;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_TARGET;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   ctpr_req_if req_chan ();
   ctpr_rsp_if rsp_chan ();

   event_word_type event_q[$];
   trim_word_type  trim_due_q[$];

   // predictor copy of the register file and loop state
   cfg_type               trim_cfg = CFG_RESET;
   logic [STAMP_IN_W-1:0] loop_stamp;
   longint                loop_period;
   longint                loop_sum;

   logic [STAMP_IN_W-1:0] plan_stamp = '0;
   int unsigned           send_gap = 0;
   int unsigned           rsp_wait = 0;
   int unsigned           rsp_hold_left = 0;
   logic                  sender_gaps_on = 1'b1;
   logic                  receiver_gaps_on = 1'b1;
   logic                  rsp_hold_go = 1'b0;
   int unsigned           words_queued = 0;
   int unsigned           words_taken = 0;
   int unsigned           results_seen = 0;
   int unsigned           mismatches = 0;
   int unsigned           settings_used = 0;
   longint unsigned       cycle_count = 0;

   clock_trim_pid_regulator_top #(
      .SUM_WIDTH      (SUM_BITS),
      .GAIN_FRAC_BITS (FRAC_BITS),
      .STAMP_WIDTH    (STAMP_BITS)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   always @(posedge clock) cycle_count <= cycle_count + 1;

   // Expected result of one event word; advances the predictor state.
   function automatic trim_word_type predict_trim(input logic kind,
                                                  input logic [STAMP_IN_W-1:0] stamp);
      trim_word_type         r;
      logic [STAMP_IN_W-1:0] gap;
      longint                tgt, win, nom, meas, per, err, acc, den, c, ps;
      logic                  oow, clip;
      tgt  = (trim_cfg.target_period_ms == '0) ? 1 : longint'(trim_cfg.target_period_ms);
      win  = longint'(trim_cfg.window_ms);
      nom  = longint'(trim_cfg.nominal_ticks);
      oow  = 1'b0;
      clip = 1'b0;
      if (kind == REQ_START) begin
         loop_stamp  = stamp;
         loop_sum    = 0;
         loop_period = tgt;
         per         = tgt;
         ps          = nom;
         if (nom == 0) begin
            ps   = 1;
            clip = 1'b1;
         end
      end else begin
         gap  = stamp - loop_stamp;            // wraps at the stamp width
         meas = longint'(gap);
         // lower bound may go negative, then only the upper one rejects
         oow  = (meas > tgt + win) || (meas < tgt - win);
         per  = oow ? tgt : meas;
         err  = tgt - per;
         acc  = loop_sum + err;
         if (acc > SUM_MAX) begin
            acc  = SUM_MAX;
            clip = 1'b1;
         end
         if (acc < SUM_MIN) begin
            acc  = SUM_MIN;
            clip = 1'b1;
         end
         loop_sum = acc;
         den = tgt <<< FRAC_BITS;
         c   = den + longint'(trim_cfg.p_gain) * err + longint'(trim_cfg.i_gain) * acc
               - longint'(trim_cfg.d_gain) * (per - loop_period);
         if (c <= 0)
            ps = 0;
         else if (c >= den * 65536)
            ps = 65536;
         else
            ps = nom * (c / den) + (nom * (c % den)) / den;
         if (ps < 1) begin
            ps   = 1;
            clip = 1'b1;
         end
         if (ps > PS_MAX) begin
            ps   = PS_MAX;
            clip = 1'b1;
         end
         loop_period = longint'(per[PERIOD_W-1:0]);
         loop_stamp  = stamp;
      end
      r.prescaler     = ps[PS_W-1:0];
      r.period_used   = per[PERIOD_W-1:0];
      r.out_of_window = oow;
      r.clamped       = clip;
      return r;
   endfunction

   task automatic flag_mismatch(input string what, input longint want, input longint got);
      mismatches++;
      if (mismatches <= 40)
         $display("%0t ns  %s: expected %0d, got %0d", $time, what, want, got);
   endtask

   // Request side: offers queued words, predicts each one at acceptance.
   always @(posedge clock) begin : word_driver
      event_word_type w;
      if (reset) begin
         req_chan.valid    <= 1'b0;
         req_chan.req_type <= REQ_START;
         req_chan.time_ms  <= '0;
         send_gap    = 0;
         loop_stamp  = '0;
         loop_period = longint'(LAST_PERIOD_RESET);
         loop_sum    = 0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            trim_due_q.push_back(predict_trim(req_chan.req_type, req_chan.time_ms));
            words_taken++;
            send_gap = sender_gaps_on ? $urandom_range(0, 7) : 0;
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (send_gap != 0 || event_q.size() == 0) begin
               req_chan.valid <= 1'b0;
               if (send_gap != 0)
                  send_gap--;
            end else begin
               w = event_q.pop_front();
               req_chan.valid    <= 1'b1;
               req_chan.req_type <= w.kind;
               req_chan.time_ms  <= w.stamp;
            end
         end
      end
   end

   // Long receiver hold-off, armed by a one-cycle pulse.
   always @(posedge clock) begin
      if (reset)
         rsp_hold_left <= 0;
      else if (rsp_hold_go)
         rsp_hold_left <= LONG_HOLD;
      else if (rsp_hold_left != 0)
         rsp_hold_left <= rsp_hold_left - 1;
   end

   // Result side: checks each accepted word against the oldest prediction.
   always @(posedge clock) begin : result_monitor
      trim_word_type want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         rsp_wait = 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            results_seen++;
            if (trim_due_q.size() == 0) begin
               flag_mismatch("result word with nothing due, prescaler", 0, rsp_chan.prescaler);
            end else begin
               want = trim_due_q.pop_front();
               if (rsp_chan.prescaler !== want.prescaler)
                  flag_mismatch("prescaler", want.prescaler, rsp_chan.prescaler);
               if (rsp_chan.period_used !== want.period_used)
                  flag_mismatch("period_used", want.period_used, rsp_chan.period_used);
               if (rsp_chan.out_of_window !== want.out_of_window)
                  flag_mismatch("out_of_window", want.out_of_window, rsp_chan.out_of_window);
               if (rsp_chan.clamped !== want.clamped)
                  flag_mismatch("clamped", want.clamped, rsp_chan.clamped);
            end
            rsp_wait = receiver_gaps_on ? $urandom_range(0, 7) : 0;
         end else if (rsp_wait != 0) begin
            rsp_wait--;
         end
         rsp_chan.ready <= (rsp_wait == 0) && (rsp_hold_left == 0);
      end
   end

   task automatic queue_word(input logic kind, input logic [STAMP_IN_W-1:0] stamp);
      event_word_type w;
      w.kind  = kind;
      w.stamp = stamp;
      event_q.push_back(w);
      words_queued++;
      plan_stamp = stamp;
   endtask

   task automatic queue_tick_after(input longint advance);
      queue_word(REQ_TICK, plan_stamp + advance[STAMP_IN_W-1:0]);
   endtask

   // Block is idle once every queued word is taken and answered.
   task automatic wait_drained();
      while (words_taken != words_queued || trim_due_q.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_TARGET:  trim_cfg.target_period_ms = data[TGT_W-1:0];
         CSR_WINDOW:  trim_cfg.window_ms        = data[WIN_W-1:0];
         CSR_NOMINAL: trim_cfg.nominal_ticks    = data[NOM_W-1:0];
         CSR_P_GAIN:  trim_cfg.p_gain           = data[GAIN_W-1:0];
         CSR_I_GAIN:  trim_cfg.i_gain           = data[GAIN_W-1:0];
         CSR_D_GAIN:  trim_cfg.d_gain           = data[GAIN_W-1:0];
         default: ;
      endcase
   endtask

   // Rewrites all six registers; unused upper bits of the narrow ones get junk.
   task automatic set_config(input logic [TGT_W-1:0] tgt, input logic [WIN_W-1:0] win,
                             input logic [15:0] nom, input logic [15:0] p_g,
                             input logic [15:0] i_g, input logic [15:0] d_g);
      logic [CSR_DATA_W-1:0] pad;
      wait_drained();
      pad = CSR_DATA_W'($urandom);
      write_reg(CSR_TARGET, {pad[CSR_DATA_W-1:TGT_W], tgt});
      pad = CSR_DATA_W'($urandom);
      write_reg(CSR_WINDOW, {pad[CSR_DATA_W-1:WIN_W], win});
      write_reg(CSR_NOMINAL, nom);
      write_reg(CSR_P_GAIN, p_g);
      write_reg(CSR_I_GAIN, i_g);
      write_reg(CSR_D_GAIN, d_g);
      settings_used++;
   endtask

   function automatic logic [15:0] pick_extreme(input logic [15:0] lo, input logic [15:0] hi);
      case ($urandom_range(0, 5))
         0: return lo;
         1: return hi;
         default: return 16'($urandom_range(lo, hi));
      endcase
   endfunction

   task automatic random_setting();
      logic [TGT_W-1:0] tgt;
      logic [WIN_W-1:0] win;
      logic [15:0]      nom;
      if ($urandom_range(0, 9) == 0)
         tgt = '0;
      else
         tgt = TGT_W'(pick_extreme(16'd1, 16'd1023));
      if ($urandom_range(0, 1) == 0)
         win = WIN_W'($urandom_range(0, tgt / 4));
      else
         win = WIN_W'(pick_extreme(16'd0, 16'd1023));
      if ($urandom_range(0, 9) == 0)
         nom = 16'd0;
      else
         nom = pick_extreme(16'd1, 16'hFFFF);
      set_config(tgt, win, nom,
                 pick_extreme(16'd0, 16'hFFFF), pick_extreme(16'd0, 16'hFFFF),
                 pick_extreme(16'd0, 16'hFFFF));
   endtask

   // Mostly plausible tick trains from a start, with window edges, wild periods,
   // stray restarts and random stamps mixed in.
   task automatic queue_random_run(input int unsigned count);
      longint      tgt, win, advance, jitter;
      int unsigned roll;
      tgt = (trim_cfg.target_period_ms == '0) ? 1 : longint'(trim_cfg.target_period_ms);
      win = longint'(trim_cfg.window_ms);
      queue_word(REQ_START, $urandom);
      for (int unsigned k = 1; k < count; k++) begin
         roll   = $urandom_range(0, 99);
         jitter = longint'($urandom_range(0, 1));
         if (roll < 4) begin
            queue_word(REQ_START, $urandom);
         end else if (roll < 8) begin
            queue_word(REQ_TICK, $urandom);
         end else begin
            if (roll < 18) begin
               advance = longint'($urandom_range(0, 2100));
            end else if (roll < 28) begin
               advance = (roll % 2 == 0) ? tgt + win + jitter : tgt - win - jitter;
            end else begin
               jitter  = longint'($urandom_range(0, 32'(2 * win + 4)));
               advance = tgt - win - 2 + jitter;
            end
            if (advance < 0)
               advance = 0;
            queue_tick_after(advance);
         end
      end
   endtask

   // Holds the result side long enough for the block to back up its input.
   task automatic stall_receiver();
      int unsigned mark;
      rsp_hold_go <= 1'b1;
      @(posedge clock);
      rsp_hold_go <= 1'b0;
      mark = results_seen + 20;
      while (rsp_hold_left != 0 || (results_seen < mark && words_taken != words_queued))
         @(posedge clock);
   endtask

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT)
         @(posedge clock);
      $display("run stopped at the cycle limit, %0d results checked", results_seen);
      $display("clock_trim_pid_regulator_top: mismatch");
      $finish;
   end

   initial begin : stimulus
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // reset settings: first tick measures from stamp zero, then window edges
      queue_tick_after(260);
      queue_word(REQ_START, 32'hFFFF_FF00);
      queue_tick_after(260);                 // stamp wraps through zero
      queue_tick_after(300);                 // upper edge, kept
      queue_tick_after(200);                 // lower edge, kept
      queue_tick_after(301);
      queue_tick_after(199);
      queue_tick_after(0);
      queue_word(REQ_START, 32'hFFFF_FFFF);
      queue_tick_after(250);

      // zero target acts as one, zero nominal forces prescaler 1
      set_config(10'd0, 10'd0, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      queue_word(REQ_START, 32'd5);
      queue_tick_after(1);
      queue_tick_after(0);
      queue_tick_after(2);

      // window wider than target: clamps at both ends of the prescaler
      set_config(10'd10, 10'd1023, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0);
      queue_word(REQ_START, 32'd1000);
      queue_tick_after(0);
      queue_tick_after(1033);
      queue_tick_after(1034);

      // largest target, no gains: prescaler exactly nominal
      set_config(10'd1023, 10'd0, 16'd1, 16'd0, 16'd0, 16'd0);
      queue_word(REQ_START, $urandom);
      queue_tick_after(1023);
      queue_tick_after(1024);

      // integral build-up: a train of zero-length periods, then back down
      set_config(10'd1023, 10'd1023, pick_extreme(16'd1, 16'hFFFF), 16'($urandom),
                 16'($urandom), 16'($urandom));
      sender_gaps_on   <= 1'b0;
      receiver_gaps_on <= 1'b0;
      queue_word(REQ_START, $urandom);
      repeat (SAT_TICKS) queue_tick_after(0);
      repeat (4) queue_tick_after(2046);

      for (int run = 0; run < RUN_COUNT; run++) begin
         random_setting();
         sender_gaps_on   <= (run != 2) && (run != 5);
         receiver_gaps_on <= (run != 2);
         queue_random_run(RUN_WORDS);
         if (run == 5)
            repeat (3) stall_receiver();
      end

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("%0d event words over %0d register settings, %0d results checked",
               words_taken, settings_used, results_seen);
      $display("window edges, stamp wrap, zero target and nominal, both clamps, long error train");
      if (mismatches == 0)
         $display("clock_trim_pid_regulator_top: match");
      else
         $display("clock_trim_pid_regulator_top: mismatch");
      $finish;
   end

endmodule
